### rtl/erfp_pkg.sv
package erfp_pkg;

  localparam int COORD_FRACTION_BITS = 4;
  localparam int CFB = COORD_FRACTION_BITS;

  localparam int PIX_W = 16;
  localparam int DIM_W = 13;
  localparam int VEC_W = 16;
  localparam int POS_W = 20;
  localparam int TAN_W = 16;
  localparam int FOC_W = 16;
  localparam int CFG_W = 60;
  localparam int ADDR_W = 3;

  // coefficient path
  localparam int WDEN_W = DIM_W + CFB;
  localparam int AX_W = ((PIX_W + 1 > WDEN_W) ? PIX_W + 1 : WDEN_W) + 1;
  localparam int PAX_W = AX_W + TAN_W + 1;
  localparam int N_W = AX_W + TAN_W + 2;
  localparam int CX_W = 24;
  localparam int CQ_W = CX_W;
  localparam int CBITS = 4;
  localparam int CDIV_ST = CQ_W / CBITS;
  localparam int CSAT_SH = CX_W - 1;
  localparam int COVF_W = (N_W > WDEN_W + CSAT_SH) ? N_W : WDEN_W + CSAT_SH;
  localparam int COEF_LIMIT = 2 ** (CX_W - 1) - 1;

  // direction and dot product
  localparam int Q14 = 14;
  localparam int HALF14 = 2 ** (Q14 - 1);
  localparam int PH_W = CX_W + VEC_W;
  localparam int D28_W = PH_W + 2;
  localparam int D14_W = D28_W - Q14;
  localparam int DOT_W = D14_W + VEC_W + 2;
  localparam int DOTU_W = DOT_W - 1;

  // focal scaling
  localparam int MAG_W = D14_W - 1;
  localparam int PR_W = MAG_W + FOC_W;
  localparam int ND_W = PR_W + Q14 + 1;
  localparam int OQ_W = 21;
  localparam int BOVF_W = (ND_W > DOTU_W + OQ_W) ? ND_W : DOTU_W + OQ_W;
  localparam int SUM_W = OQ_W + 2;
  localparam int OUT_MAX = 2 ** (POS_W - 1) - 1;
  localparam int OUT_MIN = -(2 ** (POS_W - 1));

  // queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_EYE    = 3'd0;
  localparam logic [ADDR_W-1:0] REG_VIEW   = 3'd1;
  localparam logic [ADDR_W-1:0] REG_UP     = 3'd2;
  localparam logic [ADDR_W-1:0] REG_HOR    = 3'd3;
  localparam logic [ADDR_W-1:0] REG_TAN    = 3'd4;
  localparam logic [ADDR_W-1:0] REG_WIDTH  = 3'd5;
  localparam logic [ADDR_W-1:0] REG_HEIGHT = 3'd6;
  localparam logic [ADDR_W-1:0] REG_FOCAL  = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } erfp_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] focal_x;
    logic signed [POS_W-1:0] focal_y;
    logic signed [POS_W-1:0] focal_z;
    logic                    degenerate;
  } erfp_out_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] eye;
    logic [2:0][VEC_W-1:0] view;
    logic [2:0][VEC_W-1:0] up;
    logic [2:0][VEC_W-1:0] hor;
    logic [TAN_W-1:0]      tan;
    logic [DIM_W-1:0]      width;
    logic [DIM_W-1:0]      height;
    logic [FOC_W-1:0]      focal;
  } erfp_cfg_t;

  typedef struct packed {
    logic [2:0][D14_W-1:0] d14;
    logic [DOTU_W-1:0]     dot;
    logic                  deg;
  } erfp_ray_t;

endpackage

### rtl/eye_ray_focal_point_core.sv
// channel | dir | handshake          | word
// in      | in  | in_valid/in_stall  | erfp_in_t: pixel_x, pixel_y (Q12.4)
// out     | out | out_valid/out_stall| erfp_out_t: focal_x/y/z (Q12.8), degenerate
// cfg     | in  | cfg_we             | cfg_addr selects register, cfg_wdata
// One word per cycle sustained while out_stall is low. Path: the front
// (coefficient divider, 4 quotient bits per stage), queue, then the back
// (focal divider, 1 quotient bit per stage, 3 lanes).
// rst_n synchronous: clears pipeline valids, queue and loads register defaults.
// out_stall freezes the back only; the 4-word queue lets the front keep going
// until full, then in_stall rises.
module eye_ray_focal_point_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  erfp_pkg::erfp_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output erfp_pkg::erfp_out_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [erfp_pkg::ADDR_W-1:0]           cfg_addr,
  input  logic [erfp_pkg::CFG_W-1:0]            cfg_wdata
);
  import erfp_pkg::*;

  erfp_cfg_t cfg_r;
  logic      q_full, q_empty, push, pop;
  erfp_ray_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.eye    <= '0;
      cfg_r.view   <= {VEC_W'(16384), VEC_W'(0), VEC_W'(0)};
      cfg_r.up     <= {VEC_W'(0), VEC_W'(16384), VEC_W'(0)};
      cfg_r.hor    <= {VEC_W'(0), VEC_W'(0), VEC_W'(16384)};
      cfg_r.tan    <= TAN_W'(4096);
      cfg_r.width  <= DIM_W'(1);
      cfg_r.height <= DIM_W'(1);
      cfg_r.focal  <= FOC_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_EYE:    cfg_r.eye    <= cfg_wdata;
        REG_VIEW:   cfg_r.view   <= cfg_wdata[3*VEC_W-1:0];
        REG_UP:     cfg_r.up     <= cfg_wdata[3*VEC_W-1:0];
        REG_HOR:    cfg_r.hor    <= cfg_wdata[3*VEC_W-1:0];
        REG_TAN:    cfg_r.tan    <= cfg_wdata[TAN_W-1:0];
        REG_WIDTH:  cfg_r.width  <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT: cfg_r.height <= cfg_wdata[DIM_W-1:0];
        REG_FOCAL:  cfg_r.focal  <= cfg_wdata[FOC_W-1:0];
        default:    cfg_r.focal  <= cfg_r.focal;
      endcase
    end
  end

  erfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  erfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  erfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/erfp_front.sv
module erfp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  erfp_pkg::erfp_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  erfp_pkg::erfp_in_t  in_data,
  input  logic                q_full,
  output logic                push,
  output erfp_pkg::erfp_ray_t push_data
);
  import erfp_pkg::*;

  logic en;
  logic [WDEN_W-1:0] wden;
  logic [WDEN_W-1:0] hden;

  logic v0_r, v1_r, v9_r, v10_r, v11_r, v12_r;
  logic [CDIV_ST:0] dv_r;

  logic signed [AX_W-1:0]  ax_r [2];
  logic signed [PAX_W-1:0] pax_r [2];
  logic [WDEN_W-1:0] crem_r [CDIV_ST+1][2];
  logic [CQ_W-1:0]   cnq_r  [CDIV_ST+1][2];
  logic              cneg_r [CDIV_ST+1][2];
  logic              covf_r [CDIV_ST+1][2];
  logic [WDEN_W-1:0] crem_nxt [CDIV_ST+1][2];
  logic [CQ_W-1:0]   cnq_nxt  [CDIV_ST+1][2];
  logic              cneg_nxt [2];
  logic              covf_nxt [2];
  logic signed [CX_W-1:0]  cx_r [2];
  logic signed [CX_W-1:0]  cx_nxt [2];
  logic signed [PH_W-1:0]  ph_r [3];
  logic signed [PH_W-1:0]  pu_r [3];
  logic signed [D14_W-1:0] d14_r [3];
  logic signed [D14_W-1:0] d14_nxt [3];
  logic signed [D14_W-1:0] d14b_r [3];
  logic signed [DOT_W-1:0] pd_r [3];
  logic signed [DOT_W-1:0] dot;

  assign en       = !q_full;
  assign in_stall = q_full;
  assign wden = {((cfg.width == '0) ? DIM_W'(1) : cfg.width), {CFB{1'b0}}};
  assign hden = {cfg.height, {CFB{1'b0}}};

  always_comb begin
    logic [PAX_W-1:0]  mag;
    logic [N_W-1:0]    n;
    logic [COVF_W-1:0] lhs;
    logic [COVF_W-1:0] rhs;
    logic [WDEN_W:0]   t;
    logic [WDEN_W-1:0] rem;
    logic [CQ_W-1:0]   nq;
    // divider entry: magnitude, rounding half, saturation test
    for (int j = 0; j < 2; j++) begin
      mag = pax_r[j][PAX_W-1] ? -pax_r[j] : pax_r[j];
      n   = (N_W'(mag) << 2) + N_W'(wden >> 1);
      lhs = COVF_W'(n);
      rhs = COVF_W'(wden) << CSAT_SH;
      covf_nxt[j]    = lhs >= rhs;
      cneg_nxt[j]    = pax_r[j][PAX_W-1];
      crem_nxt[0][j] = WDEN_W'(n >> CQ_W);
      cnq_nxt[0][j]  = n[CQ_W-1:0];
    end
    // restoring division, CBITS quotient bits per stage
    for (int k = 1; k <= CDIV_ST; k++) begin
      for (int j = 0; j < 2; j++) begin
        rem = crem_r[k-1][j];
        nq  = cnq_r[k-1][j];
        for (int b = 0; b < CBITS; b++) begin
          t  = {rem, nq[CQ_W-1]};
          nq = {nq[CQ_W-2:0], 1'b0};
          if (t >= {1'b0, wden}) begin
            t     = t - {1'b0, wden};
            nq[0] = 1'b1;
          end
          rem = t[WDEN_W-1:0];
        end
        crem_nxt[k][j] = rem;
        cnq_nxt[k][j]  = nq;
      end
    end
  end

  always_comb begin
    logic signed [CX_W-1:0] q;
    for (int j = 0; j < 2; j++) begin
      q = $signed(cnq_r[CDIV_ST][j]);
      if (covf_r[CDIV_ST][j]) begin
        cx_nxt[j] = cneg_r[CDIV_ST][j] ? -CX_W'(COEF_LIMIT) : CX_W'(COEF_LIMIT);
      end else begin
        cx_nxt[j] = cneg_r[CDIV_ST][j] ? -q : q;
      end
    end
  end

  // direction rounded to Q.14
  always_comb begin
    logic signed [D28_W-1:0] d28;
    logic [D28_W-1:0]        mag;
    logic [D14_W-1:0]        r;
    for (int i = 0; i < 3; i++) begin
      d28 = (D28_W'($signed(cfg.view[i])) <<< Q14) + D28_W'(ph_r[i]) + D28_W'(pu_r[i]);
      mag = d28[D28_W-1] ? -d28 : d28;
      r   = D14_W'((mag + D28_W'(HALF14)) >> Q14);
      d14_nxt[i] = d28[D28_W-1] ? -$signed(r) : $signed(r);
    end
  end

  assign dot = pd_r[0] + pd_r[1] + pd_r[2];
  assign push = v12_r && en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_data.d14[i] = d14b_r[i];
    end
    push_data.dot = dot[DOTU_W-1:0];
    push_data.deg = dot[DOT_W-1] || (dot == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      dv_r  <= '0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
    end else if (en) begin
      v0_r  <= in_valid;
      v1_r  <= v0_r;
      dv_r  <= {dv_r[CDIV_ST-1:0], v1_r};
      v9_r  <= dv_r[CDIV_ST];
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r[0] <= AX_W'({in_data.pixel_x, 1'b0}) - AX_W'(wden);
      ax_r[1] <= AX_W'({in_data.pixel_y, 1'b0}) - AX_W'(hden);
      for (int j = 0; j < 2; j++) begin
        pax_r[j]     <= PAX_W'(ax_r[j]) * PAX_W'($signed({1'b0, cfg.tan}));
        crem_r[0][j] <= crem_nxt[0][j];
        cnq_r[0][j]  <= cnq_nxt[0][j];
        cneg_r[0][j] <= cneg_nxt[j];
        covf_r[0][j] <= covf_nxt[j];
        for (int k = 1; k <= CDIV_ST; k++) begin
          crem_r[k][j] <= crem_nxt[k][j];
          cnq_r[k][j]  <= cnq_nxt[k][j];
          cneg_r[k][j] <= cneg_r[k-1][j];
          covf_r[k][j] <= covf_r[k-1][j];
        end
        cx_r[j] <= cx_nxt[j];
      end
      for (int i = 0; i < 3; i++) begin
        ph_r[i]   <= PH_W'(cx_r[0]) * PH_W'($signed(cfg.hor[i]));
        pu_r[i]   <= PH_W'(cx_r[1]) * PH_W'($signed(cfg.up[i]));
        d14_r[i]  <= d14_nxt[i];
        d14b_r[i] <= d14_r[i];
        pd_r[i]   <= DOT_W'(d14_r[i]) * DOT_W'($signed(cfg.view[i]));
      end
    end
  end

endmodule

### rtl/erfp_queue.sv
module erfp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  erfp_pkg::erfp_ray_t push_data,
  input  logic                pop,
  output erfp_pkg::erfp_ray_t pop_data,
  output logic                full,
  output logic                empty
);
  import erfp_pkg::*;

  erfp_ray_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign full     = count_r == QCNT_W'(QDEPTH);
  assign empty    = count_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("word pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("word popped from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

### rtl/erfp_back.sv
module erfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  erfp_pkg::erfp_cfg_t cfg,
  input  logic                q_empty,
  output logic                pop,
  input  erfp_pkg::erfp_ray_t pop_data,
  output logic                out_valid,
  input  logic                out_stall,
  output erfp_pkg::erfp_out_t out_data
);
  import erfp_pkg::*;

  logic en;
  logic bv0_r, bv1_r, out_valid_r;
  logic [OQ_W:0] dv_r;

  logic [MAG_W-1:0]  mag_r [3];
  logic              neg0_r [3];
  logic [DOTU_W-1:0] dot0_r, dot1_r;
  logic              deg0_r, deg1_r;
  logic [PR_W-1:0]   pr_r [3];
  logic              neg1_r [3];

  logic [DOTU_W-1:0] bdot_r [OQ_W+1];
  logic              bdeg_r [OQ_W+1];
  logic [DOTU_W-1:0] brem_r [OQ_W+1][3];
  logic [OQ_W-1:0]   bnq_r  [OQ_W+1][3];
  logic              bneg_r [OQ_W+1][3];
  logic              bovf_r [OQ_W+1][3];
  logic [DOTU_W-1:0] brem_nxt [OQ_W+1][3];
  logic [OQ_W-1:0]   bnq_nxt  [OQ_W+1][3];
  logic              bovf_nxt [3];

  erfp_out_t out_r, out_nxt;

  assign en  = !out_valid_r || !out_stall;
  assign pop = en && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [ND_W-1:0]   nd;
    logic [BOVF_W-1:0] lhs;
    logic [BOVF_W-1:0] rhs;
    logic [DOTU_W:0]   t;
    for (int i = 0; i < 3; i++) begin
      nd  = (ND_W'(pr_r[i]) << Q14) + ND_W'(dot1_r >> 1);
      lhs = BOVF_W'(nd);
      rhs = BOVF_W'(dot1_r) << OQ_W;
      bovf_nxt[i]    = lhs >= rhs;
      brem_nxt[0][i] = DOTU_W'(nd >> OQ_W);
      bnq_nxt[0][i]  = nd[OQ_W-1:0];
    end
    // one quotient bit per stage
    for (int k = 1; k <= OQ_W; k++) begin
      for (int i = 0; i < 3; i++) begin
        t = {brem_r[k-1][i], bnq_r[k-1][i][OQ_W-1]};
        bnq_nxt[k][i] = {bnq_r[k-1][i][OQ_W-2:0], 1'b0};
        if (t >= {1'b0, bdot_r[k-1]}) begin
          t = t - {1'b0, bdot_r[k-1]};
          bnq_nxt[k][i][0] = 1'b1;
        end
        brem_nxt[k][i] = t[DOTU_W-1:0];
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] offs;
    logic signed [SUM_W-1:0] sum;
    logic signed [POS_W-1:0] res [3];
    for (int i = 0; i < 3; i++) begin
      offs = $signed({2'b00, bnq_r[OQ_W][i]});
      if (bneg_r[OQ_W][i]) begin
        offs = -offs;
      end
      sum = SUM_W'($signed(cfg.eye[i])) + offs;
      if (bdeg_r[OQ_W]) begin
        res[i] = $signed(cfg.eye[i]);
      end else if (bovf_r[OQ_W][i]) begin
        res[i] = bneg_r[OQ_W][i] ? POS_W'(OUT_MIN) : POS_W'(OUT_MAX);
      end else if (sum > SUM_W'(OUT_MAX)) begin
        res[i] = POS_W'(OUT_MAX);
      end else if (sum < SUM_W'(OUT_MIN)) begin
        res[i] = POS_W'(OUT_MIN);
      end else begin
        res[i] = sum[POS_W-1:0];
      end
    end
    out_nxt.focal_x    = res[0];
    out_nxt.focal_y    = res[1];
    out_nxt.focal_z    = res[2];
    out_nxt.degenerate = bdeg_r[OQ_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv0_r       <= 1'b0;
      bv1_r       <= 1'b0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      bv0_r       <= pop;
      bv1_r       <= bv0_r;
      dv_r        <= {dv_r[OQ_W-1:0], bv1_r};
      out_valid_r <= dv_r[OQ_W];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [D14_W-1:0] d;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d = $signed(pop_data.d14[i]);
        neg0_r[i] <= d[D14_W-1];
        mag_r[i]  <= d[D14_W-1] ? MAG_W'(-d) : MAG_W'(d);
        pr_r[i]   <= PR_W'(mag_r[i]) * PR_W'(cfg.focal);
        neg1_r[i] <= neg0_r[i];
        brem_r[0][i] <= brem_nxt[0][i];
        bnq_r[0][i]  <= bnq_nxt[0][i];
        bneg_r[0][i] <= neg1_r[i];
        bovf_r[0][i] <= bovf_nxt[i];
        for (int k = 1; k <= OQ_W; k++) begin
          brem_r[k][i] <= brem_nxt[k][i];
          bnq_r[k][i]  <= bnq_nxt[k][i];
          bneg_r[k][i] <= bneg_r[k-1][i];
          bovf_r[k][i] <= bovf_r[k-1][i];
        end
      end
      dot0_r    <= pop_data.dot;
      deg0_r    <= pop_data.deg;
      dot1_r    <= dot0_r;
      deg1_r    <= deg0_r;
      bdot_r[0] <= dot1_r;
      bdeg_r[0] <= deg1_r;
      for (int k = 1; k <= OQ_W; k++) begin
        bdot_r[k] <= bdot_r[k-1];
        bdeg_r[k] <= bdeg_r[k-1];
      end
      out_r <= out_nxt;
    end
  end

endmodule

### tb/sv/eye_ray_focal_point_core_test.sv
`timescale 1ns / 1ps

module eye_ray_focal_point_core_test;
  import erfp_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;

  class focal_scoreboard;
    logic [59:0] eye;
    logic [47:0] view, up, hor;
    logic [15:0] tan, focal;
    logic [12:0] width, height;
    erfp_out_t   pending[$];
    int          errors;

    function new();
      eye = '0; view = 48'h4000_0000_0000; up = 48'h0000_4000_0000;
      hor = 48'h0000_0000_4000; tan = 16'd4096; width = 13'd1; height = 13'd1;
      focal = 16'd512; errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(logic [ADDR_W-1:0] a, logic [CFG_W-1:0] v);
      case (a)
        REG_EYE:    eye = v[59:0];
        REG_VIEW:   view = v[47:0];
        REG_UP:     up = v[47:0];
        REG_HOR:    hor = v[47:0];
        REG_TAN:    tan = v[15:0];
        REG_WIDTH:  width = v[12:0];
        REG_HEIGHT: height = v[12:0];
        REG_FOCAL:  focal = v[15:0];
        default: ;
      endcase
    endfunction

    function longint sx(longint v, int bits);
      v = v & ((64'sd1 <<< bits) - 1);
      if (v[bits-1]) v = v - (64'sd1 <<< bits);
      return v;
    endfunction

    function longint rdiv(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function void note_pixel(erfp_in_t w);
      longint wden, ax, ay, cx, cy, dot, v, h, u, p;
      longint d14[3];
      longint ep[3];
      erfp_out_t e;
      wden = ((width == 0) ? 64'sd1 : longint'(width)) <<< CFB;
      ax = 2 * longint'(w.pixel_x) - wden;
      ay = 2 * longint'(w.pixel_y) - (longint'(height) <<< CFB);
      cx = clip(rdiv(ax * longint'(tan) * 4, wden), -COEF_LIMIT, COEF_LIMIT);
      cy = clip(rdiv(ay * longint'(tan) * 4, wden), -COEF_LIMIT, COEF_LIMIT);
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        v = sx(longint'(view >> (16 * i)), 16);
        h = sx(longint'(hor >> (16 * i)), 16);
        u = sx(longint'(up >> (16 * i)), 16);
        d14[i] = rdiv(v * 16384 + cx * h + cy * u, 16384);
        dot += d14[i] * v;
        ep[i] = sx(longint'(eye >> (20 * i)), 20);
      end
      for (int i = 0; i < 3; i++) begin
        if (dot <= 0) p = ep[i];
        else p = clip(ep[i] + rdiv(d14[i] * longint'(focal) * 16384, dot), OUT_MIN, OUT_MAX);
        ep[i] = p;
      end
      e.focal_x = ep[0][19:0];
      e.focal_y = ep[1][19:0];
      e.focal_z = ep[2][19:0];
      e.degenerate = (dot <= 0);
      pending.push_back(e);
    endfunction

    task check_word(erfp_out_t got);
      erfp_out_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %h", got));
        return;
      end
      e = pending.pop_front();
      if (got.focal_x !== e.focal_x)
        report($sformatf("focal_x got %h exp %h", got.focal_x, e.focal_x));
      if (got.focal_y !== e.focal_y)
        report($sformatf("focal_y got %h exp %h", got.focal_y, e.focal_y));
      if (got.focal_z !== e.focal_z)
        report($sformatf("focal_z got %h exp %h", got.focal_z, e.focal_z));
      if (got.degenerate !== e.degenerate)
        report($sformatf("degenerate got %b exp %b", got.degenerate, e.degenerate));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  erfp_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  erfp_out_t out_data;
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  focal_scoreboard sb = new();
  bit hold_req = 0;
  bit no_idle = 0;
  int idle_cnt = 0;

  always #2 clk = ~clk;

  eye_ray_focal_point_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("FAIL eye_ray_focal_point_core");
      $finish;
    end
  end

  initial begin
    int n;
    @(posedge clk);
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 3);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pixel(logic [15:0] x, logic [15:0] y);
    int gap;
    erfp_in_t w;
    w.pixel_x = x;
    w.pixel_y = y;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [ADDR_W-1:0] a, logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(a, v);
  endtask

  task automatic set_all(logic [59:0] eye, logic [47:0] view, logic [47:0] up,
                         logic [47:0] hor, logic [15:0] tan, logic [12:0] w,
                         logic [12:0] h, logic [15:0] f);
    cfg_write(REG_EYE, CFG_W'(eye));
    cfg_write(REG_VIEW, CFG_W'(view));
    cfg_write(REG_UP, CFG_W'(up));
    cfg_write(REG_HOR, CFG_W'(hor));
    cfg_write(REG_TAN, CFG_W'(tan));
    cfg_write(REG_WIDTH, CFG_W'(w));
    cfg_write(REG_HEIGHT, CFG_W'(h));
    cfg_write(REG_FOCAL, CFG_W'(f));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [47:0] rand_vec();
    logic [47:0] v;
    int ax;
    if ($urandom_range(0, 3) == 0) return 48'({$urandom, $urandom});
    v = '0;
    for (int i = 0; i < 3; i++) v[16*i +: 16] = 16'($signed($urandom_range(0, 2000)) - 1000);
    ax = $urandom_range(0, 2);
    v[16*ax +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
    return v;
  endfunction

  function automatic logic [12:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'd8191;
      default: return 13'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic send_random();
    logic [16:0] xr, yr;
    if ($urandom_range(0, 4) == 0) begin
      send_pixel(16'($urandom), 16'($urandom));
    end else begin
      xr = 17'($urandom_range(0, ((sb.width == 0 ? 1 : sb.width) << CFB)));
      yr = 17'($urandom_range(0, (sb.height << CFB) + 16));
      send_pixel(xr[15:0], yr[15:0]);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'd8, 16'd8);
    send_pixel(16'd16, 16'd0);
    send_pixel(16'h5555, 16'hAAAA);
    drain();

    // horizon folded onto -z: ray turns back at dot zero and below
    set_all({20'h00000, 20'h80000, 20'h7FFFF}, 48'h4000_0000_0000, 48'h0000_4000_0000,
            48'hC000_0000_0000, 16'd4096, 13'd1, 13'd1, 16'hFFFF);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'd16, 16'd8);
    send_pixel(16'd32, 16'd8);
    send_pixel(16'd4, 16'd12);
    send_pixel(16'd1, 16'hFFFF);
    drain();

    // zero width and height, coefficient clamp
    set_all({20'h7FFFF, 20'h7FFFF, 20'h80000}, 48'h4000_0000_0000, 48'h0000_4000_0000,
            48'h0000_0000_4000, 16'hFFFF, 13'd0, 13'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'd8, 16'd0);
    drain();

    // zero view vector, oversized image
    set_all('0, 48'd0, 48'h0000_4000_0000, 48'h0000_0000_4000,
            16'd0, 13'd8191, 13'd8191, 16'd0);
    send_pixel(16'd100, 16'd200);
    send_pixel(16'hFFFF, 16'hFFFF);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0)
        set_all('0, '0, '0, '0, '0, '0, '0, '0);
      else if (ph == 1)
        set_all('1, '1, '1, '1, '1, '1, '1, '1);
      else
        set_all(60'({$urandom, $urandom}) & 60'h0FF_FF0F_FF0F_FFFF
                  | 60'($urandom_range(0, 1) ? '1 : '0) & 60'h800_0080_0080_0000,
                rand_vec(), rand_vec(), rand_vec(),
                $urandom_range(0, 1) ? 16'($urandom_range(1024, 8192)) : 16'($urandom),
                rand_dim(), rand_dim(),
                $urandom_range(0, 1) ? 16'($urandom_range(0, 4096)) : 16'($urandom));
      no_idle = (ph == 5);
      for (int k = 0; k < 110; k++) begin
        if (ph == 3 && k == 20) hold_req = 1;
        send_random();
      end
      drain();
    end
    no_idle = 0;

    if (sb.pending.size() != 0) sb.report("expected words left over");
    if (sb.errors == 0) begin
      $display("PASS eye_ray_focal_point_core");
    end else begin
      $display("FAIL eye_ray_focal_point_core");
    end
    $finish;
  end

endmodule

### files.f
rtl/erfp_pkg.sv
rtl/erfp_front.sv
rtl/erfp_queue.sv
rtl/erfp_back.sv
rtl/eye_ray_focal_point_core.sv
tb/sv/eye_ray_focal_point_core_test.sv
